// File: rtl/prrt_pkg.sv
`default_nettype none
package prrt_pkg;
    localparam int SLOTS = 64;
    localparam int IW = $clog2(SLOTS);
    localparam int QDEPTH = 2;

    typedef enum logic [2:0] {
        CMD_OPEN = 3'd0, CMD_CLOSE = 3'd1, CMD_LEVEL = 3'd2,
        CMD_COMM = 3'd3, CMD_SETMAX = 3'd4, CMD_START = 3'd5,
        CMD_X6 = 3'd6, CMD_X7 = 3'd7
    } t_cmd;

    localparam logic [2:0] KIND_FAIL = 3'd0;
    localparam logic [2:0] KIND_UNREC = 3'd1;
    localparam logic [2:0] KIND_OPEN = 3'd2;
    localparam logic [2:0] KIND_CLOSE = 3'd3;
    localparam logic [2:0] KIND_LEVEL = 3'd4;
    localparam logic [2:0] KIND_COMM = 3'd5;
    localparam logic [2:0] KIND_SETMAX = 3'd6;
    localparam logic [2:0] KIND_START = 3'd7;

    // One classified item passed from the front to the back.
    typedef struct packed {
        logic        add;
        logic [2:0]  cmd;
        logic [29:0] value;
        logic [15:0] tag;
        logic        do_match;
        logic [2:0]  want;
        logic        use_value;
        logic [29:0] reply_value;
        logic        do_sweep;
    } t_job;

    function automatic logic cmd_has_value(input logic [2:0] c);
        case (c)
            CMD_OPEN, CMD_CLOSE, CMD_SETMAX, CMD_X6, CMD_X7: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction
endpackage
`default_nettype wire

// File: rtl/pending_reply_retry_table.sv
`default_nettype none
// Channel   | Direction | Contents
// s_axis    | in        | command/reply transaction, has_new and reply_kind in tuser
// m_axis    | out       | resend transaction, tlast on the final one of an item
// cfg       | in        | retry_limit write, accepted only while the block is idle
//
// An item leaves the queue, then passes a free-slot search over the used bits,
// then a match scan and a sweep that read each slot from memory, then compare it.
// A found resend waits until the output register is empty, so a sink stall can
// hold the sweep until the register is free.
// Reset is synchronous and empties the table at once through per-slot used bits.
// A two-entry queue lets the front accept items while the back is busy, and
// an output register holds a resend transaction while the sink stalls.
module pending_reply_retry_table (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: new_cmd[2:0], new_value[32:3], new_tag[48:33],
    //        reply_value[78:49], zero fill
    input  wire logic [79:0] s_axis_tdata,
    // tuser: has_new[0], reply_kind[3:1]
    input  wire logic [3:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: resend_tag[15:0], resend_cmd[18:16], resend_value[48:19], zero fill
    output logic [55:0]      m_axis_tdata,
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_data
);
    import prrt_pkg::*;
    logic [7:0] r_limit;
    logic       push, full, qvalid, pop, idle;
    t_job       fjob, qjob;

    // The limit only changes while no item is queued or being processed.
    assign o_cfg_ready = idle;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_limit <= 8'd8;
        else if (i_cfg_valid && o_cfg_ready) r_limit <= i_cfg_data;
    end

    prrt_front u_front (.s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .o_push(push), .o_job(fjob), .i_full(full));
    prrt_queue u_queue (.i_clk, .i_rst_n, .i_push(push), .i_job(fjob),
        .o_full(full), .o_valid(qvalid), .o_job(qjob), .i_pop(pop));
    prrt_back u_back (.i_clk, .i_rst_n, .i_limit(r_limit), .i_valid(qvalid),
        .i_job(qjob), .o_pop(pop), .m_axis_tvalid, .m_axis_tready,
        .m_axis_tdata, .m_axis_tlast, .o_idle(idle));
endmodule
`default_nettype wire

// File: rtl/prrt_front.sv
`default_nettype none
module prrt_front (
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire logic [79:0]    s_axis_tdata,
    input  wire logic [3:0]     s_axis_tuser,
    output logic                o_push,
    output prrt_pkg::t_job      o_job,
    input  wire logic           i_full
);
    import prrt_pkg::*;
    logic [2:0] kind;

    assign s_axis_tready = !i_full;
    assign o_push = s_axis_tvalid && !i_full;
    assign kind = s_axis_tuser[3:1];

    always_comb begin
        o_job.add = s_axis_tuser[0];
        o_job.cmd = s_axis_tdata[2:0];
        o_job.value = cmd_has_value(s_axis_tdata[2:0]) ? s_axis_tdata[32:3] : 30'd0;
        o_job.tag = s_axis_tdata[48:33];
        o_job.do_match = (kind != KIND_FAIL) && (kind != KIND_UNREC);
        o_job.want = kind - 3'd2;
        o_job.use_value = (kind == KIND_OPEN) || (kind == KIND_CLOSE) ||
                          (kind == KIND_SETMAX);
        o_job.reply_value = s_axis_tdata[78:49];
        o_job.do_sweep = (kind != KIND_FAIL);
    end
endmodule
`default_nettype wire

// File: rtl/prrt_queue.sv
`default_nettype none
module prrt_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire prrt_pkg::t_job i_job,
    output logic                o_full,
    output logic                o_valid,
    output prrt_pkg::t_job      o_job,
    input  wire logic           i_pop
);
    import prrt_pkg::*;
    t_job       r_mem [QDEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full = (r_cnt == 2'(QDEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_job = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule
`default_nettype wire

// File: rtl/prrt_back.sv
`default_nettype none
module prrt_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [7:0]     i_limit,
    input  wire logic           i_valid,
    input  wire prrt_pkg::t_job i_job,
    output logic                o_pop,
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    output logic [55:0]         m_axis_tdata,
    output logic                m_axis_tlast,
    output logic                o_idle
);
    import prrt_pkg::*;
    typedef enum logic [2:0] {S_IDLE, S_ADD, S_MATCH, S_SWEEP, S_OUT} t_state;

    // Used bits in flops; miss counts and payload in memories with a registered read.
    logic [SLOTS-1:0] r_used;
    logic [7:0]       r_miss [SLOTS];
    logic [2:0]       r_cmd_mem [SLOTS];
    logic [29:0]      r_val_mem [SLOTS];
    logic [15:0]      r_tag_mem [SLOTS];

    t_state      r_state;
    t_job        r_job;
    logic [IW:0] r_idx;
    logic [IW-1:0] idx;
    logic [2:0]  r_rcmd;
    logic [29:0] r_rval;
    logic [15:0] r_rtag;
    logic [7:0]  r_rmiss;
    logic        r_rd_ok;
    logic        r_have;   // a candidate is buffered awaiting "last" decision
    logic [48:0] r_pend;
    logic        r_ovalid;
    logic [48:0] r_odata;
    logic        r_olast;
    logic        done_scan;

    assign idx = r_idx[IW-1:0];
    assign done_scan = (r_idx == (IW+1)'(SLOTS));
    assign o_pop = (r_state == S_IDLE) && i_valid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {7'd0, r_odata};
    assign m_axis_tlast = r_olast;
    assign o_idle = (r_state == S_IDLE) && !i_valid && !r_ovalid;

    always_ff @(posedge i_clk) begin
        // Memory read, registered ahead of use.
        r_rcmd <= r_cmd_mem[idx];
        r_rval <= r_val_mem[idx];
        r_rtag <= r_tag_mem[idx];
        r_rmiss <= r_miss[idx];
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used <= '0;
            r_ovalid <= 1'b0;
            r_rd_ok <= 1'b0;
            r_have <= 1'b0;
            r_idx <= '0;
        end else begin
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_job <= i_job;
                        r_idx <= '0;
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    if (!r_job.add || done_scan) begin
                        r_idx <= '0;
                        r_rd_ok <= 1'b0;
                        r_state <= r_job.do_match ? S_MATCH :
                                   (r_job.do_sweep ? S_SWEEP : S_IDLE);
                    end else if (!r_used[idx]) begin
                        r_used[idx] <= 1'b1;
                        r_miss[idx] <= 8'd0;
                        r_cmd_mem[idx] <= r_job.cmd;
                        r_val_mem[idx] <= r_job.value;
                        r_tag_mem[idx] <= r_job.tag;
                        r_idx <= '0;
                        r_rd_ok <= 1'b0;
                        r_state <= r_job.do_match ? S_MATCH :
                                   (r_job.do_sweep ? S_SWEEP : S_IDLE);
                    end else begin
                        r_idx <= r_idx + (IW+1)'(1);
                    end
                end
                S_MATCH: begin
                    // Alternate between fetching a slot and comparing it.
                    if (done_scan) begin
                        r_idx <= '0;
                        r_state <= S_SWEEP;
                    end else if (!r_rd_ok) begin
                        r_rd_ok <= 1'b1;
                    end else begin
                        r_rd_ok <= 1'b0;
                        if (r_used[idx]) begin
                            if (r_rcmd == r_job.want &&
                                (!r_job.use_value || r_rval == r_job.reply_value)) begin
                                r_used[idx] <= 1'b0;
                                r_idx <= '0;
                                r_state <= S_SWEEP;
                            end else begin
                                if (r_rmiss != 8'hFF) r_miss[idx] <= r_rmiss + 8'd1;
                                r_idx <= r_idx + (IW+1)'(1);
                            end
                        end else begin
                            r_idx <= r_idx + (IW+1)'(1);
                        end
                    end
                end
                S_SWEEP: begin
                    // A found slot is held in r_pend until the next one (or the
                    // end of the table) tells whether it is the last.
                    if (done_scan) begin
                        if (r_have && !r_ovalid) begin
                            r_ovalid <= 1'b1;
                            r_odata <= r_pend;
                            r_olast <= 1'b1;
                            r_have <= 1'b0;
                            r_state <= S_IDLE;
                        end else if (!r_have) begin
                            r_state <= S_IDLE;
                        end
                    end else if (!r_rd_ok) begin
                        r_rd_ok <= 1'b1;
                    end else if (r_used[idx] && r_rmiss >= i_limit) begin
                        if (!r_have) begin
                            r_pend <= {r_rval, r_rcmd, r_rtag};
                            r_have <= 1'b1;
                            r_used[idx] <= 1'b0;
                            r_idx <= r_idx + (IW+1)'(1);
                            r_rd_ok <= 1'b0;
                        end else if (!r_ovalid) begin
                            r_ovalid <= 1'b1;
                            r_odata <= r_pend;
                            r_olast <= 1'b0;
                            r_pend <= {r_rval, r_rcmd, r_rtag};
                            r_used[idx] <= 1'b0;
                            r_idx <= r_idx + (IW+1)'(1);
                            r_rd_ok <= 1'b0;
                        end
                    end else begin
                        r_idx <= r_idx + (IW+1)'(1);
                        r_rd_ok <= 1'b0;
                    end
                end
                S_OUT: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: sim/tb_pending_reply_retry_table.sv
`default_nettype none
module tb_pending_reply_retry_table;
    import prrt_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_ITEMS = 350;
    localparam int DRAIN_CYCLES = 600;

    // Fields of one resend transaction.
    typedef struct packed {
        logic [15:0] tag;
        logic [2:0]  cmd;
        logic [29:0] value;
        logic        last;
    } t_resend;

    // One input item; exp_count < 0 means no typed-in expectation.
    typedef struct {
        logic        has_new;
        logic [2:0]  cmd;
        logic [29:0] value;
        logic [15:0] tag;
        logic [2:0]  kind;
        logic [29:0] reply_value;
        int          exp_count;
    } t_item;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [79:0]  s_axis_tdata = '0;
    logic [3:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [55:0]  m_axis_tdata;
    logic         m_axis_tlast;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [7:0]   i_cfg_data = '0;

    pending_reply_retry_table u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the pending table.
    logic        pend_used [SLOTS];
    logic [2:0]  pend_cmd [SLOTS];
    logic [29:0] pend_value [SLOTS];
    logic [15:0] pend_tag [SLOTS];
    logic [7:0]  pend_misses [SLOTS];
    logic [7:0]  retry_limit;

    t_resend resend_queue [$];
    int      error_count = 0;
    int      cycle_count = 0;
    bit      sink_hold = 1'b0;
    bit      calm = 1'b0;

    task automatic report_mismatch(input string what);
        error_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    function automatic bit cmd_keeps_value(input logic [2:0] c);
        return c == CMD_OPEN || c == CMD_CLOSE || c == CMD_SETMAX ||
               c == CMD_X6 || c == CMD_X7;
    endfunction

    function automatic void clear_pending();
        for (int i = 0; i < SLOTS; i++) begin
            pend_used[i] = 1'b0;
            pend_cmd[i] = '0;
            pend_value[i] = '0;
            pend_tag[i] = '0;
            pend_misses[i] = '0;
        end
    endfunction

    // Applies one item to the shadow table and queues the resends it causes.
    function automatic int predict_resends(input t_item it);
        logic [2:0] want;
        bit         use_val;
        int         n;
        int         first;
        n = 0;
        first = resend_queue.size();
        if (it.has_new) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (!pend_used[i]) begin
                    pend_used[i] = 1'b1;
                    pend_cmd[i] = it.cmd;
                    pend_value[i] = cmd_keeps_value(it.cmd) ? it.value : '0;
                    pend_tag[i] = it.tag;
                    pend_misses[i] = '0;
                    break;
                end
            end
        end
        if (it.kind == KIND_FAIL) return 0;
        if (it.kind != KIND_UNREC) begin
            want = it.kind - 3'd2;
            use_val = it.kind == KIND_OPEN || it.kind == KIND_CLOSE ||
                      it.kind == KIND_SETMAX;
            for (int i = 0; i < SLOTS; i++) begin
                if (!pend_used[i]) continue;
                if (pend_cmd[i] == want && (!use_val || pend_value[i] == it.reply_value)) begin
                    pend_used[i] = 1'b0;
                    pend_misses[i] = '0;
                    break;
                end
                if (pend_misses[i] != 8'hFF) pend_misses[i]++;
            end
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (pend_used[i] && pend_misses[i] >= retry_limit) begin
                resend_queue.push_back({pend_tag[i], pend_cmd[i], pend_value[i], 1'b0});
                pend_used[i] = 1'b0;
                pend_misses[i] = '0;
                n++;
            end
        end
        if (n > 0) resend_queue[first + n - 1].last = 1'b1;
        return n;
    endfunction

    task automatic send_item(input t_item it);
        int n;
        while (!calm && $urandom_range(99) < 25) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tdata <= {1'b0, it.reply_value, it.tag, it.value, it.cmd};
        s_axis_tuser <= {it.kind, it.has_new};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        n = predict_resends(it);
        if (it.exp_count >= 0 && n != it.exp_count)
            report_mismatch($sformatf("predicted %0d resends, table row says %0d",
                                      n, it.exp_count));
    endtask

    task automatic write_limit(input logic [7:0] lim);
        s_axis_tvalid <= 1'b0;
        while (resend_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_data <= lim;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        retry_limit = lim;
    endtask

    function automatic t_item random_item();
        t_item it;
        int r;
        it.has_new = $urandom_range(99) < 60;
        it.cmd = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6))
                                          : 3'($urandom_range(5));
        // Small value pool so that replies match pending commands often.
        r = $urandom_range(9);
        it.value = (r < 7) ? 30'(r) : 30'($urandom);
        it.tag = 16'($urandom);
        it.kind = 3'($urandom_range(7));
        r = $urandom_range(9);
        it.reply_value = (r < 7) ? 30'(r) : 30'($urandom);
        it.exp_count = -1;
        return it;
    endfunction

    // Sink side: random stalls, plus one long hold-off during the fill test.
    always @(posedge i_clk) begin
        m_axis_tready <= !sink_hold && (calm || $urandom_range(99) >= 25);
        if (m_axis_tvalid && m_axis_tready) begin
            if (resend_queue.size() == 0) begin
                report_mismatch("resend transaction with none expected");
            end else begin
                t_resend e;
                e = resend_queue.pop_front();
                if (m_axis_tdata[15:0] !== e.tag)
                    report_mismatch($sformatf("tag %h, expected %h", m_axis_tdata[15:0], e.tag));
                if (m_axis_tdata[18:16] !== e.cmd)
                    report_mismatch($sformatf("cmd %0d, expected %0d",
                                              m_axis_tdata[18:16], e.cmd));
                if (m_axis_tdata[48:19] !== e.value)
                    report_mismatch($sformatf("value %0d, expected %0d",
                                              m_axis_tdata[48:19], e.value));
                if (m_axis_tlast !== e.last)
                    report_mismatch($sformatf("tlast %b, expected %b", m_axis_tlast, e.last));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        t_item dir_table [$];
        t_item it;
        logic [7:0] limits [5];
        clear_pending();
        retry_limit = 8'd8;
        limits = '{8'd1, 8'd255, 8'd3, 8'd2, 8'd8};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows at reset limit 8.
        dir_table.push_back('{1, CMD_OPEN, 30'h3FFFFFFF, 16'hFFFF, KIND_FAIL, 0, 0});
        dir_table.push_back('{1, CMD_CLOSE, 0, 16'h0000, KIND_UNREC, 0, 0});
        dir_table.push_back('{1, CMD_LEVEL, 30'd999999999, 16'h1234, KIND_OPEN,
                              30'h3FFFFFFF, -1});
        dir_table.push_back('{1, CMD_COMM, 5, 16'h0001, KIND_CLOSE, 0, -1});
        dir_table.push_back('{1, CMD_SETMAX, 30'd999999999, 16'h8000, KIND_LEVEL, 0, -1});
        dir_table.push_back('{1, CMD_START, 7, 16'h5555, KIND_COMM, 0, -1});
        dir_table.push_back('{1, CMD_X6, 30'h2AAAAAAA, 16'hAAAA, KIND_SETMAX,
                              30'd999999999, -1});
        dir_table.push_back('{1, CMD_X7, 30'h15555555, 16'h7FFF, KIND_START, 0, -1});
        dir_table.push_back('{0, CMD_OPEN, 0, 0, KIND_OPEN, 30'h15555555, -1});
        for (int k = 0; k < 10; k++)
            dir_table.push_back('{0, CMD_OPEN, 0, 0, KIND_START, 1, -1});
        dir_table.push_back('{0, CMD_OPEN, 0, 0, KIND_UNREC, 0, -1});
        dir_table.push_back('{0, CMD_OPEN, 0, 0, KIND_FAIL, 0, 0});
        foreach (dir_table[k]) send_item(dir_table[k]);

        // Fill the table beyond capacity at limit 255, then hold off the sink at limit 1.
        write_limit(8'd255);
        for (int k = 0; k < SLOTS + 4; k++)
            send_item('{1, 3'(k % 6), 30'(k), 16'(k), KIND_FAIL, 0, 0});
        write_limit(8'd1);
        fork
            begin
                sink_hold = 1'b1;
                repeat (3000) @(posedge i_clk);
                sink_hold = 1'b0;
            end
            for (int k = 0; k < 8; k++) begin
                it = random_item();
                it.kind = KIND_START;
                send_item(it);
            end
        join

        // Random phases through several limits, one stretch without idling.
        for (int p = 0; p < 5; p++) begin
            write_limit(limits[p]);
            calm = (p == 2);
            for (int k = 0; k < RANDOM_ITEMS / 5; k++) send_item(random_item());
        end
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (resend_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire
